>>> rtl/ppbc_pkg.sv
// Shared types, constants and helpers of the per-position base counter.
// No dependencies; used by ppbc_ctrl, ppbc_dp and the top level.
`default_nettype none

package ppbc_pkg;

  localparam int DEF_MAX_POS    = 1024;
  localparam int DEF_COUNT_BITS = 32;
  localparam int NUM_CLS        = 5;
  localparam int CUR_BITS       = 16;
  localparam int OUT_BITS       = 32;

  localparam logic [2:0] CLS_A = 3'd0;
  localparam logic [2:0] CLS_T = 3'd1;
  localparam logic [2:0] CLS_G = 3'd2;
  localparam logic [2:0] CLS_C = 3'd3;
  localparam logic [2:0] CLS_N = 3'd4;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_G  = 8'h67;
  localparam logic [7:0] CH_LC_C  = 8'h63;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic exec;
    logic write;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic store_hit;
    logic out_free;
  } status_t;

  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [7:0] l;
    l = b | CH_CASE;
    unique case (l)
      CH_LC_A: return CLS_A;
      CH_LC_T: return CLS_T;
      CH_LC_G: return CLS_G;
      CH_LC_C: return CLS_C;
      default: return CLS_N;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/ppbc_ctrl.sv
// Controller of the per-position base counter: clearing pass, accept,
// execute, read-modify-write and result load. Depends on ppbc_pkg.
`default_nettype none

module ppbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  ppbc_pkg::status_t status,
  input  logic              in_valid,
  output logic              in_ready,
  output ppbc_pkg::cmd_t    cmd
);
  import ppbc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (status.is_query) state_next = S_LOAD;
        else if (status.store_hit)    state_next = S_WRITE;
        else                          state_next = S_IDLE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_IDLE;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ppbc_dp.sv
// Datapath of the per-position base counter: position store, totals,
// read state and the result register. Depends on ppbc_pkg.
`default_nettype none

module ppbc_dp #(
  parameter int MAX_POS    = ppbc_pkg::DEF_MAX_POS,
  parameter int COUNT_BITS = ppbc_pkg::DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  ppbc_pkg::cmd_t    cmd,
  output ppbc_pkg::status_t status,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              func,
  input  logic [7:0]        seq_byte,
  input  logic [9:0]        query_position,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       pos_count_a,
  output logic [31:0]       pos_count_t,
  output logic [31:0]       pos_count_g,
  output logic [31:0]       pos_count_c,
  output logic [31:0]       pos_count_n,
  output logic [31:0]       sum_a,
  output logic [31:0]       sum_t,
  output logic [31:0]       sum_g,
  output logic [31:0]       sum_c,
  output logic [31:0]       sum_n,
  output logic [31:0]       reads_seen,
  output logic [15:0]       last_read_length
);
  import ppbc_pkg::*;

  localparam int AW   = $clog2(MAX_POS);
  localparam int CMPW = CUR_BITS + 1;
  localparam logic [CMPW-1:0] MAX_POS_C = CMPW'(MAX_POS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_POS - 1);

  typedef logic [NUM_CLS-1:0][COUNT_BITS-1:0] row_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_BITS-1:0] clamp(input logic [COUNT_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w[63:OUT_BITS] != '0) ? '1 : w[OUT_BITS-1:0];
  endfunction

  row_t mem [MAX_POS];
  row_t rd_row;
  row_t row_mod;
  row_t mem_wdata;

  logic                 func_r;
  logic [7:0]           byte_r;
  logic [9:0]           qpos_r;
  logic                 skipping;
  logic [CUR_BITS-1:0]  cursor;
  logic [CUR_BITS-1:0]  latched_length;
  logic [OUT_BITS-1:0]  read_counter;
  row_t                 totals;
  logic                 bw_enable;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        wr_addr;
  logic [2:0]           wr_cls;
  logic [NUM_CLS-1:0][OUT_BITS-1:0] pos_r;
  logic [NUM_CLS-1:0][OUT_BITS-1:0] sum_r;
  logic [OUT_BITS-1:0]  reads_r;
  logic [CUR_BITS-1:0]  len_r;

  logic          is_nl;
  logic          is_space;
  logic [2:0]    cls;
  logic          cur_in_range;
  logic          q_in_range;
  logic [AW-1:0] cidx;
  logic [AW-1:0] qidx;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  assign is_nl        = (byte_r == CH_NL);
  assign is_space     = (byte_r == CH_SPACE);
  assign cls          = classify(byte_r);
  assign cur_in_range = ({1'b0, cursor} < MAX_POS_C);
  assign q_in_range   = (CMPW'(qpos_r) < MAX_POS_C);
  assign cidx         = AW'(cursor);
  assign qidx         = AW'(qpos_r);
  assign rd_addr      = func_r ? qidx : cidx;

  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.is_query   = func_r;
  assign status.store_hit  = !func_r && !is_nl && !skipping && !is_space && cur_in_range;
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      row_mod[k] = (wr_cls == 3'(k)) ? sat_inc(rd_row[k]) : rd_row[k];
    end
  end

  assign mem_we    = cmd.clear_step | cmd.write;
  assign mem_waddr = cmd.clear_step ? clr_addr : wr_addr;
  assign mem_wdata = cmd.clear_step ? '0 : row_mod;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_row <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      byte_r <= seq_byte;
      qpos_r <= query_position;
    end
    if (cmd.exec) begin
      wr_addr <= cidx;
      wr_cls  <= cls;
    end
    if (cmd.load) begin
      for (int k = 0; k < NUM_CLS; k++) begin
        pos_r[k] <= (bw_enable && q_in_range) ? clamp(rd_row[k]) : '0;
        sum_r[k] <= clamp(totals[k]);
      end
      reads_r <= read_counter;
      len_r   <= latched_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skipping       <= 1'b0;
      cursor         <= '0;
      latched_length <= '0;
      read_counter   <= '0;
      totals         <= '0;
      bw_enable      <= 1'b1;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) bw_enable <= cfg_wr_data;
      if (cmd.clear_step) clr_addr <= clr_addr + AW'(1);
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.exec && !func_r) begin
        if (is_nl) begin
          if (read_counter != '1) read_counter <= read_counter + OUT_BITS'(1);
          latched_length <= cursor;
          cursor         <= '0;
          skipping       <= 1'b0;
        end else if (!skipping) begin
          if (is_space) begin
            skipping <= 1'b1;
          end else begin
            totals[cls] <= sat_inc(totals[cls]);
            if (cursor != '1) cursor <= cursor + CUR_BITS'(1);
          end
        end
      end
    end
  end

  assign pos_count_a      = pos_r[CLS_A];
  assign pos_count_t      = pos_r[CLS_T];
  assign pos_count_g      = pos_r[CLS_G];
  assign pos_count_c      = pos_r[CLS_C];
  assign pos_count_n      = pos_r[CLS_N];
  assign sum_a            = sum_r[CLS_A];
  assign sum_t            = sum_r[CLS_T];
  assign sum_g            = sum_r[CLS_G];
  assign sum_c            = sum_r[CLS_C];
  assign sum_n            = sum_r[CLS_N];
  assign reads_seen       = reads_r;
  assign last_read_length = len_r;

endmodule

`default_nettype wire

>>> rtl/per_position_base_counter.sv
// Top level of the per-position base counter: controller plus datapath.
// Depends on ppbc_pkg, ppbc_ctrl and ppbc_dp.
`default_nettype none

// Counts A/T/G/C/other bytes per read position and in total over a stream of
// newline-separated reads; a query transaction returns one position's counts,
// the totals, the read count and the last read length. After reset the
// position store is cleared one row per cycle, so in_ready stays low until
// the clearing pass reaches the last row. A transaction is accepted and
// executed, then a byte that lands inside the store gets a write step and a
// query a load step: the store has a registered read, so a counter update
// is a read then a write. A query's result sits in an output register; the
// block takes no new transaction until that register is free to receive it.
module per_position_base_counter_core #(
  parameter int MAX_POS    = ppbc_pkg::DEF_MAX_POS,
  parameter int COUNT_BITS = ppbc_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  seq_byte,
  input  logic [9:0]  query_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pos_count_a,
  output logic [31:0] pos_count_t,
  output logic [31:0] pos_count_g,
  output logic [31:0] pos_count_c,
  output logic [31:0] pos_count_n,
  output logic [31:0] sum_a,
  output logic [31:0] sum_t,
  output logic [31:0] sum_g,
  output logic [31:0] sum_c,
  output logic [31:0] sum_n,
  output logic [31:0] reads_seen,
  output logic [15:0] last_read_length
);
  import ppbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  ppbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ppbc_dp #(
    .MAX_POS    (MAX_POS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .func             (func),
    .seq_byte         (seq_byte),
    .query_position   (query_position),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .pos_count_a      (pos_count_a),
    .pos_count_t      (pos_count_t),
    .pos_count_g      (pos_count_g),
    .pos_count_c      (pos_count_c),
    .pos_count_n      (pos_count_n),
    .sum_a            (sum_a),
    .sum_t            (sum_t),
    .sum_g            (sum_g),
    .sum_c            (sum_c),
    .sum_n            (sum_n),
    .reads_seen       (reads_seen),
    .last_read_length (last_read_length)
  );

endmodule

`default_nettype wire

>>> rtl/ppbc_checker.sv
// Port-level checks of the per-position base counter, bound to the top.
// Depends on per_position_base_counter_core.
`default_nettype none

module ppbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sum_a
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_a))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ports active right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted back to back");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func && !out_valid |=> ##2 out_valid)
    else $error("query result missing");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !func && !out_valid |=> !out_valid)
    else $error("byte transaction produced a result");

endmodule

bind per_position_base_counter_core ppbc_checker u_ppbc_checker (.*);

`default_nettype wire

>>> bench/per_position_base_counter_core_tb.sv
// Self-checking testbench for per_position_base_counter_core.
// Drives byte and query transactions and checks each query result against a built-in predictor.
// Depends on ppbc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module per_position_base_counter_core_tb;
  import ppbc_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_POS;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 8;

  typedef logic [11:0][31:0] tally_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [7:0]  seq_byte = 8'h00;
  logic [9:0]  query_position = 10'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pos_count_a, pos_count_t, pos_count_g, pos_count_c, pos_count_n;
  logic [31:0] sum_a, sum_t, sum_g, sum_c, sum_n;
  logic [31:0] reads_seen;
  logic [15:0] last_read_length;

  // predictor state
  bit [31:0] pos_tally [NUM_CLS][STORE_DEPTH];
  bit [31:0] base_total [NUM_CLS];
  bit [31:0] read_total;
  bit [15:0] read_pos;
  bit [15:0] last_len;
  bit        skip_rest;
  bit        basewise_on = 1'b1;

  tally_rec_t expected_q [$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  bit         valid_low = 1'b1;
  logic [31:0] cycle_count = '0;

  string field_name [12] = '{"pos_count_a", "pos_count_t", "pos_count_g", "pos_count_c",
                             "pos_count_n", "sum_a", "sum_t", "sum_g", "sum_c", "sum_n",
                             "reads_seen", "last_read_length"};

  logic [7:0] base_letters [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

  per_position_base_counter_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .seq_byte         (seq_byte),
    .query_position   (query_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pos_count_a      (pos_count_a),
    .pos_count_t      (pos_count_t),
    .pos_count_g      (pos_count_g),
    .pos_count_c      (pos_count_c),
    .pos_count_n      (pos_count_n),
    .sum_a            (sum_a),
    .sum_t            (sum_t),
    .sum_g            (sum_g),
    .sum_c            (sum_c),
    .sum_n            (sum_n),
    .reads_seen       (reads_seen),
    .last_read_length (last_read_length)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern, changes character as cycle_count[11:10] advances
  always @(posedge clk) begin
    unique case (cycle_count[11:10])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (cycle_count[2:0] < 3'd3);
      default: out_ready <= (cycle_count[5:3] != 3'd0);
    endcase
  end

  function automatic logic [2:0] base_class(input logic [7:0] b);
    unique case (b | CH_CASE)
      CH_LC_A: return CLS_A;
      CH_LC_T: return CLS_T;
      CH_LC_G: return CLS_G;
      CH_LC_C: return CLS_C;
      default: return CLS_N;
    endcase
  endfunction

  function automatic void count_byte(input logic [7:0] b);
    logic [2:0] cls;
    if (b == CH_NL) begin
      if (read_total != '1) read_total++;
      last_len = read_pos;
      read_pos = '0;
      skip_rest = 1'b0;
    end else if (!skip_rest) begin
      if (b == CH_SPACE) begin
        skip_rest = 1'b1;
      end else begin
        cls = base_class(b);
        if (read_pos < STORE_DEPTH && pos_tally[cls][read_pos] != '1)
          pos_tally[cls][read_pos]++;
        if (base_total[cls] != '1) base_total[cls]++;
        if (read_pos != '1) read_pos++;
      end
    end
  endfunction

  function automatic tally_rec_t query_counts(input logic [9:0] pos);
    tally_rec_t rec;
    for (int k = 0; k < NUM_CLS; k++) begin
      rec[k] = basewise_on ? pos_tally[k][pos] : 32'h0;
      rec[5 + k] = base_total[k];
    end
    rec[10] = read_total;
    rec[11] = {16'h0, last_len};
    return rec;
  endfunction

  always @(posedge clk) begin : check_results
    tally_rec_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {{16'h0, last_read_length}, reads_seen, sum_n, sum_c, sum_g, sum_t, sum_a,
             pos_count_n, pos_count_c, pos_count_g, pos_count_t, pos_count_a};
      if (expected_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected result transaction at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (got[k] !== want[k]) begin
            if (fail_count < 10)
              $display("mismatch %s: expected %0d, got %0d", field_name[k], want[k], got[k]);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_item(input logic is_query, input logic [7:0] b, input logic [9:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        if (!valid_low) in_valid <= 1'b0;
        valid_low = 1'b1;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    func <= is_query;
    seq_byte <= b;
    query_position <= pos;
    valid_low = 1'b0;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    if (is_query) expected_q.push_back(query_counts(pos));
    else count_byte(b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b, 10'($urandom));
  endtask

  task automatic send_query(input logic [9:0] pos);
    send_item(1'b1, 8'($urandom), pos);
  endtask

  function automatic logic [7:0] random_base();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return base_letters[$urandom_range(0, 7)];
  endfunction

  // space_at < 0: no space in the read
  task automatic send_read(input int len, input int space_at, input bit terminated);
    for (int i = 0; i < len; i++) begin
      if (i == space_at) send_byte(CH_SPACE);
      else send_byte(random_base());
    end
    if (terminated) send_byte(CH_NL);
  endtask

  task automatic set_basewise(input bit on);
    if (!valid_low) in_valid <= 1'b0;
    valid_low = 1'b1;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    basewise_on = on;
  endtask

  task automatic test_directed();
    logic [7:0] bytes [13] = '{"A", "a", "T", "t", "G", "g", "C", "c", "N", 8'h40, 8'hE1,
                               8'h00, 8'hFF};
    send_query(10'd0);
    foreach (bytes[i]) send_byte(bytes[i]);
    send_byte(CH_SPACE);
    send_byte("A");
    send_byte(CH_NL);
    send_byte(CH_NL);
    send_query(10'd0);
    send_query(10'd12);
    send_query(10'd13);
    send_query(10'd1023);
  endtask

  task automatic test_basewise_off();
    set_basewise(1'b0);
    send_read(20, -1, 1'b1);
    send_query(10'd0);
    send_query(10'd5);
    send_read(8, 3, 1'b1);
    send_query(10'd2);
    set_basewise(1'b1);
    send_query(10'd0);
    send_query(10'd5);
  endtask

  task automatic test_random_stream(input int count);
    int stop;
    int pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_read($urandom_range(0, 30), -1, 1'b1);
      end else if (pick < 60) begin
        send_read($urandom_range(1, 30), $urandom_range(0, 20), 1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) send_query(10'($urandom));
          else send_query(10'($urandom_range(0, 40)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random();
    test_random_stream(220);
    set_basewise(1'b0);
    test_random_stream(220);
    set_basewise(1'b1);
    test_random_stream(200);
    set_basewise(1'b0);
    test_random_stream(120);
    set_basewise(1'b1);
    test_random_stream(100);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_basewise_off();
    test_random();
    if (!valid_low) in_valid <= 1'b0;
    valid_low = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
